FILE: rtl/core/splm_pkg.sv
package splm_pkg;

	localparam int SAMPLE_BITS  = 24;
	localparam int COEF_BITS    = 16;
	localparam int DB_FRAC_BITS = 8;

	localparam int LEVEL_BITS = SAMPLE_BITS - 1;
	localparam int DB_BITS    = 17;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [LEVEL_BITS-1:0]         level_t;
	typedef logic [COEF_BITS-1:0]          coef_t;
	typedef logic signed [DB_BITS-1:0]     db_t;

	localparam level_t FULL_SCALE = '1;
	localparam coef_t  COEF_RESET = COEF_BITS'((64'd64173 << COEF_BITS) >> 16);

	// smoother accumulator: mag*2^C + a*(prev - mag) + 2^(C-1)
	localparam int ACC_W = LEVEL_BITS + COEF_BITS + 2;
	localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (COEF_BITS - 1);

	// log2 in Q16: exponent plus fraction bits found by repeated squaring
	localparam int FRAC_W   = 16;
	localparam int MANT_W   = 31;
	localparam int E_W      = $clog2(LEVEL_BITS);
	localparam int LOG_W    = E_W + FRAC_W;
	localparam int SQ_STEPS = FRAC_W;

	// 20*log10(2) in Q16
	localparam int                 DB_PER_OCT_W = 19;
	localparam logic [DB_PER_OCT_W-1:0] DB_PER_OCT = 19'd394566;
	localparam int PROD_W  = LOG_W + DB_PER_OCT_W;
	localparam int RND_SH  = 32 - DB_FRAC_BITS;
	localparam int MAG_W   = (PROD_W + 1 - RND_SH > DB_BITS) ? PROD_W + 1 - RND_SH : DB_BITS;
	localparam int SUM_W   = MAG_W + RND_SH;
	localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (RND_SH - 1);
	localparam logic [MAG_W-1:0] DB_SAT   = MAG_W'(65536);

	// dB unit stages: normalize, squaring steps, subtract, multiply, round
	localparam int ST_NORM   = 0;
	localparam int ST_SUB    = SQ_STEPS + 1;
	localparam int ST_MUL    = SQ_STEPS + 2;
	localparam int ST_RND    = SQ_STEPS + 3;
	localparam int DB_STAGES = SQ_STEPS + 4;

	// input, smoother, block peak, then the dB unit
	localparam int PIPE_STAGES = 3 + DB_STAGES;

	function automatic logic [LOG_W-1:0] log2_q16(input logic [63:0] x);
		logic [63:0]       xv;
		logic [63:0]       m;
		logic [FRAC_W-1:0] fr;
		int                e;
		xv = (x == 64'd0) ? 64'd1 : x;
		e  = 0;
		for (int i = 1; i < 64; i++) begin
			if ((xv >> i) != 64'd0)
				e = i;
		end
		if (e <= 30)
			m = xv << (30 - e);
		else
			m = xv >> (e - 30);
		fr = '0;
		for (int i = 0; i < FRAC_W; i++) begin
			m  = (m * m) >> 30;
			fr = {fr[FRAC_W-2:0], (m >= (64'd2 << 30))};
			if (m >= (64'd2 << 30))
				m = m >> 1;
		end
		return LOG_W'((64'(e) << FRAC_W) | 64'(fr));
	endfunction

	localparam logic [LOG_W-1:0] LOG_FS = log2_q16(64'(FULL_SCALE));

endpackage

FILE: rtl/core/splm_db.sv
module splm_db (
	input  logic                              clk,
	input  logic [splm_pkg::DB_STAGES-1:0]    en,
	input  splm_pkg::level_t                  val_in,
	output splm_pkg::level_t                  val_out,
	output splm_pkg::db_t                     db_out
);
	import splm_pkg::*;

	level_t            val_s  [DB_STAGES];
	logic [E_W-1:0]    exp_s  [SQ_STEPS+1];
	logic [MANT_W-1:0] mant_s [SQ_STEPS+1];
	logic [FRAC_W-1:0] frac_s [SQ_STEPS+1];
	logic [LOG_W-1:0]  dist_s;
	logic [PROD_W-1:0] prod_s;
	db_t               db_s;

	logic [E_W-1:0]    exp_n;
	logic [MANT_W-1:0] mant_n;
	logic [MANT_W-1:0] sq_mant_n [SQ_STEPS+1];
	logic              sq_bit_n  [SQ_STEPS+1];
	logic [2*MANT_W-1:0] sq;
	logic [MANT_W:0]   sq_top;
	logic [LOG_W-1:0]  log_x;
	logic [LOG_W-1:0]  dist_n;
	logic [SUM_W-1:0]  rnd_sum;
	logic [MAG_W-1:0]  mag;
	logic [MAG_W-1:0]  mag_sat;
	db_t               db_n;

	// leading one sets the exponent; mantissa lands in Q30
	always_comb begin
		exp_n = '0;
		for (int i = 1; i < LEVEL_BITS; i++) begin
			if (val_in[i])
				exp_n = E_W'(i);
		end
		mant_n = MANT_W'(val_in) << (MANT_W - 1 - int'(exp_n));
	end

	// each step squares the mantissa and peels one fraction bit
	always_comb begin
		sq_mant_n[0] = '0;
		sq_bit_n[0]  = 1'b0;
		sq           = '0;
		sq_top       = '0;
		for (int k = 1; k <= SQ_STEPS; k++) begin
			sq           = mant_s[k-1] * mant_s[k-1];
			sq_top       = sq[2*MANT_W-1:MANT_W-1];
			sq_bit_n[k]  = sq_top[MANT_W];
			sq_mant_n[k] = sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
		end
	end

	assign log_x  = {exp_s[SQ_STEPS], frac_s[SQ_STEPS]};
	assign dist_n = (LOG_FS > log_x) ? LOG_FS - log_x : '0;

	always_comb begin
		rnd_sum = SUM_W'(prod_s) + RND_HALF;
		mag     = rnd_sum[SUM_W-1:RND_SH];
		mag_sat = (mag > DB_SAT) ? DB_SAT : mag;
		db_n    = db_t'(~mag_sat[DB_BITS-1:0] + 1'b1);
	end

	always_ff @(posedge clk) begin
		if (en[ST_NORM]) begin
			val_s[ST_NORM]  <= val_in;
			exp_s[0]        <= exp_n;
			mant_s[0]       <= mant_n;
			frac_s[0]       <= '0;
		end
		for (int k = 1; k <= SQ_STEPS; k++) begin
			if (en[k]) begin
				val_s[k]  <= val_s[k-1];
				exp_s[k]  <= exp_s[k-1];
				mant_s[k] <= sq_mant_n[k];
				frac_s[k] <= {frac_s[k-1][FRAC_W-2:0], sq_bit_n[k]};
			end
		end
		if (en[ST_SUB]) begin
			val_s[ST_SUB] <= val_s[ST_SUB-1];
			dist_s        <= dist_n;
		end
		if (en[ST_MUL]) begin
			val_s[ST_MUL] <= val_s[ST_MUL-1];
			prod_s        <= PROD_W'(dist_s) * PROD_W'(DB_PER_OCT);
		end
		if (en[ST_RND]) begin
			val_s[ST_RND] <= val_s[ST_RND-1];
			db_s          <= db_n;
		end
	end

	assign val_out = val_s[ST_RND];
	assign db_out  = db_s;

endmodule

FILE: rtl/core/stereo_peak_level_meter.sv
// Channel   Handshake                 Payload
// config    cfg_wr_en                 cfg_wr_data (smoothing coefficient)
// input     in_valid / in_ready       left_sample, right_sample, last_of_block
// output    out_valid / out_ready     levels, level dB, block peaks, peak dB, block_end
//
// One sample pair per cycle unless a stalled output backs up the pipe. The dB
// unit holds 16 squaring stages of the log2 mantissa plus normalize, subtract,
// multiply and round stages, after the input, smoother and peak stages.
// Reset sets the coefficient to its default, the smoother state to one LSB and
// the block peaks to zero. A stalled output holds its stage; earlier stages keep
// filling any empty slot, so in_ready stays high while the pipe has a bubble.
module stereo_peak_level_meter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  splm_pkg::coef_t   cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  splm_pkg::sample_t left_sample,
	input  splm_pkg::sample_t right_sample,
	input  logic              last_of_block,
	output logic              out_valid,
	input  logic              out_ready,
	output splm_pkg::level_t  level_left,
	output splm_pkg::level_t  level_right,
	output splm_pkg::db_t     level_db_left,
	output splm_pkg::db_t     level_db_right,
	output splm_pkg::level_t  block_peak_left,
	output splm_pkg::level_t  block_peak_right,
	output splm_pkg::db_t     block_peak_db_left,
	output splm_pkg::db_t     block_peak_db_right,
	output logic              block_end
);
	import splm_pkg::*;

	function automatic level_t magnitude(input sample_t s);
		logic [SAMPLE_BITS-1:0] a;
		a = s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s) : SAMPLE_BITS'(s);
		return (a > {1'b0, FULL_SCALE}) ? FULL_SCALE : a[LEVEL_BITS-1:0];
	endfunction

	function automatic level_t smooth(input level_t prev, input level_t mag, input coef_t a);
		logic signed [LEVEL_BITS:0]     diff;
		logic signed [ACC_W-1:0]        prod;
		logic signed [ACC_W-1:0]        acc;
		logic [LEVEL_BITS+1:0]          lev;
		diff = $signed({1'b0, prev}) - $signed({1'b0, mag});
		prod = $signed({1'b0, a}) * diff;
		acc  = $signed({2'b00, mag, {COEF_BITS{1'b0}}}) + prod + ACC_HALF;
		lev  = acc[ACC_W-1:COEF_BITS];
		if (lev == '0)
			return level_t'(1);
		else if (lev > {2'b00, FULL_SCALE})
			return FULL_SCALE;
		else
			return lev[LEVEL_BITS-1:0];
	endfunction

	logic [PIPE_STAGES-1:0] vld_s;
	logic [PIPE_STAGES-1:0] en;
	logic [DB_STAGES-1:0]   last_d_s;

	coef_t  coef_q;
	level_t prev_l_q, prev_r_q;
	level_t pk_l_q, pk_r_q;

	level_t mag_l_s1, mag_r_s1;
	logic   last_s1;
	level_t lvl_l_s2, lvl_r_s2;
	logic   last_s2;
	level_t lvl_l_s3, lvl_r_s3, pk_l_s3, pk_r_s3;
	logic   last_s3;

	level_t lvl_l_n, lvl_r_n, pk_l_n, pk_r_n;

	// a stage loads when it is empty or its successor moves
	always_comb begin
		en[PIPE_STAGES-1] = !vld_s[PIPE_STAGES-1] || out_ready;
		for (int k = PIPE_STAGES - 2; k >= 0; k--)
			en[k] = !vld_s[k] || en[k+1];
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0])
				vld_s[0] <= in_valid;
			for (int k = 1; k < PIPE_STAGES; k++) begin
				if (en[k])
					vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (cfg_wr_en) begin
			coef_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en[0]) begin
			mag_l_s1 <= magnitude(left_sample);
			mag_r_s1 <= magnitude(right_sample);
			last_s1  <= last_of_block;
		end
	end

	// smoother
	assign lvl_l_n = smooth(prev_l_q, mag_l_s1, coef_q);
	assign lvl_r_n = smooth(prev_r_q, mag_r_s1, coef_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= level_t'(1);
			prev_r_q <= level_t'(1);
		end else if (en[1] && vld_s[0]) begin
			prev_l_q <= lvl_l_n;
			prev_r_q <= lvl_r_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			lvl_l_s2 <= lvl_l_n;
			lvl_r_s2 <= lvl_r_n;
			last_s2  <= last_s1;
		end
	end

	// block peak; drop it to zero after the last beat of a block
	assign pk_l_n = (lvl_l_s2 > pk_l_q) ? lvl_l_s2 : pk_l_q;
	assign pk_r_n = (lvl_r_s2 > pk_r_q) ? lvl_r_s2 : pk_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_l_q <= '0;
			pk_r_q <= '0;
		end else if (en[2] && vld_s[1]) begin
			pk_l_q <= last_s2 ? '0 : pk_l_n;
			pk_r_q <= last_s2 ? '0 : pk_r_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			lvl_l_s3 <= lvl_l_s2;
			lvl_r_s3 <= lvl_r_s2;
			pk_l_s3  <= pk_l_n;
			pk_r_s3  <= pk_r_n;
			last_s3  <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[PIPE_STAGES-DB_STAGES])
			last_d_s[0] <= last_s3;
		for (int k = 1; k < DB_STAGES; k++) begin
			if (en[PIPE_STAGES-DB_STAGES+k])
				last_d_s[k] <= last_d_s[k-1];
		end
	end

	splm_db u_db_lvl_l (
		.clk     (clk),
		.en      (en[PIPE_STAGES-1:PIPE_STAGES-DB_STAGES]),
		.val_in  (lvl_l_s3),
		.val_out (level_left),
		.db_out  (level_db_left)
	);

	splm_db u_db_lvl_r (
		.clk     (clk),
		.en      (en[PIPE_STAGES-1:PIPE_STAGES-DB_STAGES]),
		.val_in  (lvl_r_s3),
		.val_out (level_right),
		.db_out  (level_db_right)
	);

	splm_db u_db_pk_l (
		.clk     (clk),
		.en      (en[PIPE_STAGES-1:PIPE_STAGES-DB_STAGES]),
		.val_in  (pk_l_s3),
		.val_out (block_peak_left),
		.db_out  (block_peak_db_left)
	);

	splm_db u_db_pk_r (
		.clk     (clk),
		.en      (en[PIPE_STAGES-1:PIPE_STAGES-DB_STAGES]),
		.val_in  (pk_r_s3),
		.val_out (block_peak_right),
		.db_out  (block_peak_db_right)
	);

	assign out_valid = vld_s[PIPE_STAGES-1];
	assign block_end = last_d_s[DB_STAGES-1];

	a_level_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level_left != '0 && level_right != '0))
		else $error("smoothed level below one LSB");

	a_peak_covers_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (block_peak_left >= level_left && block_peak_right >= level_right))
		else $error("block peak below current level");

	a_db_not_positive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level_db_left <= 0 && level_db_right <= 0 &&
			block_peak_db_left <= 0 && block_peak_db_right <= 0))
		else $error("dB value above full scale");

	a_peak_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(en[2] && vld_s[1] && last_s2) |=> (pk_l_q == '0 && pk_r_q == '0))
		else $error("block peak not cleared after last beat");

endmodule

FILE: verif/splm_meter_checker.sv
module splm_meter_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  splm_pkg::coef_t   cfg_wr_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  splm_pkg::sample_t left_sample,
	input  splm_pkg::sample_t right_sample,
	input  logic              last_of_block,
	input  logic              out_valid,
	input  logic              out_ready,
	input  splm_pkg::level_t  level_left,
	input  splm_pkg::level_t  level_right,
	input  splm_pkg::db_t     level_db_left,
	input  splm_pkg::db_t     level_db_right,
	input  splm_pkg::level_t  block_peak_left,
	input  splm_pkg::level_t  block_peak_right,
	input  splm_pkg::db_t     block_peak_db_left,
	input  splm_pkg::db_t     block_peak_db_right,
	input  logic              block_end,
	output int                fail_count,
	output int                pending,
	output int                results_seen
);

	import splm_pkg::*;

	typedef struct packed {
		level_t level_l;
		level_t level_r;
		db_t    db_l;
		db_t    db_r;
		level_t peak_l;
		level_t peak_r;
		db_t    peak_db_l;
		db_t    peak_db_r;
		logic   blk_end;
	} meter_result_t;

	meter_result_t expected_meter_q[$];
	meter_result_t want;
	meter_result_t got;

	coef_t  alpha;
	level_t env_l;
	level_t env_r;
	level_t hold_l;
	level_t hold_r;
	int     errors;
	int     seen;

	// log2 in Q16: integer part from the top set bit, fraction by squaring
	function automatic logic [31:0] octave_log_q16(input level_t x);
		logic [63:0] mant;
		logic [15:0] frac;
		level_t      v;
		int          msb;
		v   = (x == '0) ? level_t'(1) : x;
		msb = 0;
		for (int b = 0; b < LEVEL_BITS; b++)
			if (v[b])
				msb = b;
		mant = {{(64-LEVEL_BITS){1'b0}}, v} << (30 - msb);
		frac = '0;
		for (int k = 0; k < 16; k++) begin
			mant = (mant * mant) >> 30;
			frac = frac << 1;
			if (mant[31]) begin
				frac[0] = 1'b1;
				mant    = mant >> 1;
			end
		end
		return (32'(msb) << 16) | 32'(frac);
	endfunction

	function automatic db_t level_to_db(input level_t lev);
		logic [31:0] top_log;
		logic [31:0] lev_log;
		logic [63:0] span;
		logic [63:0] mag;
		top_log = octave_log_q16(FULL_SCALE);
		lev_log = octave_log_q16(lev);
		span    = (top_log > lev_log) ? 64'(top_log - lev_log) : 64'd0;
		mag     = (span * 64'd394566 + (64'd1 << (31 - DB_FRAC_BITS))) >> (32 - DB_FRAC_BITS);
		if (mag > 64'd65536)
			mag = 64'd65536;
		return DB_BITS'(64'd0 - mag);
	endfunction

	function automatic level_t sample_mag(input sample_t s);
		logic [63:0] raw;
		logic [63:0] m;
		raw = {{(64-SAMPLE_BITS){1'b0}}, s};
		m   = s[SAMPLE_BITS-1] ? (64'd1 << SAMPLE_BITS) - raw : raw;
		return (m > 64'(FULL_SCALE)) ? FULL_SCALE : level_t'(m);
	endfunction

	function automatic level_t smooth_level(input level_t prev, input level_t mag,
			input coef_t a);
		logic [63:0] acc;
		acc = 64'(a) * 64'(prev) + ((64'd1 << COEF_BITS) - 64'(a)) * 64'(mag)
			+ (64'd1 << (COEF_BITS - 1));
		acc = acc >> COEF_BITS;
		if (acc < 64'd1)
			acc = 64'd1;
		if (acc > 64'(FULL_SCALE))
			acc = 64'(FULL_SCALE);
		return level_t'(acc);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha  = COEF_RESET;
			env_l  = level_t'(1);
			env_r  = level_t'(1);
			hold_l = '0;
			hold_r = '0;
			errors = 0;
			seen   = 0;
			expected_meter_q.delete();
			fail_count   <= 0;
			pending      <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_wr_en)
				alpha = cfg_wr_data;

			if (in_valid && in_ready) begin
				env_l = smooth_level(env_l, sample_mag(left_sample), alpha);
				env_r = smooth_level(env_r, sample_mag(right_sample), alpha);
				if (env_l > hold_l)
					hold_l = env_l;
				if (env_r > hold_r)
					hold_r = env_r;
				want.level_l   = env_l;
				want.level_r   = env_r;
				want.db_l      = level_to_db(env_l);
				want.db_r      = level_to_db(env_r);
				want.peak_l    = hold_l;
				want.peak_r    = hold_r;
				want.peak_db_l = level_to_db(hold_l);
				want.peak_db_r = level_to_db(hold_r);
				want.blk_end   = last_of_block;
				expected_meter_q = {expected_meter_q, want};
				// clear the block maximum after the closing sample
				if (last_of_block) begin
					hold_l = '0;
					hold_r = '0;
				end
			end

			if (out_valid && out_ready) begin
				got.level_l   = level_left;
				got.level_r   = level_right;
				got.db_l      = level_db_left;
				got.db_r      = level_db_right;
				got.peak_l    = block_peak_left;
				got.peak_r    = block_peak_right;
				got.peak_db_l = block_peak_db_left;
				got.peak_db_r = block_peak_db_right;
				got.blk_end   = block_end;
				seen++;
				if (expected_meter_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("meter beat %0d arrived with nothing outstanding", seen);
				end else begin
					want = expected_meter_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$write("meter beat %0d exp: lvl %0d/%0d db %0d/%0d",
								seen, want.level_l, want.level_r, $signed(want.db_l),
								$signed(want.db_r));
							$display(" pk %0d/%0d pkdb %0d/%0d end %0b",
								want.peak_l, want.peak_r, $signed(want.peak_db_l),
								$signed(want.peak_db_r), want.blk_end);
							$write("meter beat %0d got: lvl %0d/%0d db %0d/%0d",
								seen, got.level_l, got.level_r, $signed(got.db_l),
								$signed(got.db_r));
							$display(" pk %0d/%0d pkdb %0d/%0d end %0b",
								got.peak_l, got.peak_r, $signed(got.peak_db_l),
								$signed(got.peak_db_r), got.blk_end);
						end
					end
				end
			end

			fail_count   <= errors;
			pending      <= expected_meter_q.size();
			results_seen <= seen;
		end
	end

endmodule

FILE: verif/tb_stereo_peak_level_meter.sv
module tb_stereo_peak_level_meter;

	import splm_pkg::*;

	localparam int     WATCHDOG_LIMIT = 4000;
	localparam int     DRAIN_CYCLES   = PIPE_STAGES + 8;
	localparam int     PHASE_ITEMS    = 190;
	localparam sample_t S_MAX     = 24'h7FFFFF;
	localparam sample_t S_MIN     = 24'h800000;
	localparam sample_t S_NEG_MAX = 24'h800001;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cfg_wr_en = 1'b0;
	coef_t   cfg_wr_data = '0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	sample_t left_sample = '0;
	sample_t right_sample = '0;
	logic    last_of_block = 1'b0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	level_t  level_left;
	level_t  level_right;
	db_t     level_db_left;
	db_t     level_db_right;
	level_t  block_peak_left;
	level_t  block_peak_right;
	db_t     block_peak_db_left;
	db_t     block_peak_db_right;
	logic    block_end;

	int fail_count;
	int pending;
	int results_seen;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int idle_run = 0;
	int pairs_sent = 0;
	int blocks_closed = 0;
	int coef_writes = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	stereo_peak_level_meter u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.left_sample        (left_sample),
		.right_sample       (right_sample),
		.last_of_block      (last_of_block),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.level_left         (level_left),
		.level_right        (level_right),
		.level_db_left      (level_db_left),
		.level_db_right     (level_db_right),
		.block_peak_left    (block_peak_left),
		.block_peak_right   (block_peak_right),
		.block_peak_db_left (block_peak_db_left),
		.block_peak_db_right(block_peak_db_right),
		.block_end          (block_end)
	);

	splm_meter_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.left_sample        (left_sample),
		.right_sample       (right_sample),
		.last_of_block      (last_of_block),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.level_left         (level_left),
		.level_right        (level_right),
		.level_db_left      (level_db_left),
		.level_db_right     (level_db_right),
		.block_peak_left    (block_peak_left),
		.block_peak_right   (block_peak_right),
		.block_peak_db_left (block_peak_db_left),
		.block_peak_db_right(block_peak_db_right),
		.block_end          (block_end),
		.fail_count         (fail_count),
		.pending            (pending),
		.results_seen       (results_seen)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat on either channel for %0d cycles", idle_run);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_pair(input sample_t l, input sample_t r, input logic last);
		in_valid      <= 1'b1;
		left_sample   <= l;
		right_sample  <= r;
		last_of_block <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pairs_sent++;
		if (last)
			blocks_closed++;
		// drop valid for a random gap after the beat
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic load_coef(input coef_t v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		coef_writes++;
	endtask

	function automatic sample_t pick_sample();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return sample_t'($urandom);
		else if (roll < 70)
			return sample_t'($signed($urandom_range(512)) - 256);
		else if (roll < 80)
			return '0;
		else if (roll < 90) begin
			case ($urandom_range(3))
				0: return S_MAX;
				1: return S_MIN;
				2: return S_NEG_MAX;
				default: return '0;
			endcase
		end
		return S_MAX - sample_t'($urandom_range(4095));
	endfunction

	initial begin
		coef_t coef_plan[6];
		int    blk_len;
		int    n;

		coef_plan[0] = 16'hFFFF;
		coef_plan[1] = 16'h0001;
		coef_plan[2] = 16'h8000;
		coef_plan[3] = coef_t'($urandom);
		coef_plan[4] = COEF_RESET;
		coef_plan[5] = 16'h0000;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default coefficient out of reset: floor, full scale, most negative
		push_pair('0, '0, 1'b0);
		push_pair(S_MAX, S_MIN, 1'b0);
		push_pair(S_MIN, S_MAX, 1'b0);
		push_pair(S_NEG_MAX, sample_t'(1), 1'b1);
		push_pair(sample_t'(-1), '0, 1'b0);
		push_pair('0, S_MAX, 1'b1);

		// zero coefficient: level follows the magnitude directly
		load_coef(16'h0000);
		push_pair('0, '0, 1'b0);
		push_pair(S_MAX, S_MIN, 1'b0);
		push_pair(S_MIN, sample_t'(-1), 1'b0);
		push_pair(sample_t'(1), sample_t'(-2), 1'b1);
		push_pair(24'h400000, 24'hC00000, 1'b0);
		push_pair(S_NEG_MAX, '0, 1'b1);
		push_pair(sample_t'(12345), sample_t'(-12345), 1'b1);

		// heaviest smoothing
		load_coef(16'hFFFF);
		push_pair(S_MAX, S_MAX, 1'b0);
		push_pair(S_MAX, S_MIN, 1'b1);

		for (int p = 0; p < 6; p++) begin
			load_coef(coef_plan[p]);
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
				default: begin src_idle_pct = 26; sink_stall_pct = 26; end
			endcase
			n = 0;
			while (n < PHASE_ITEMS) begin
				blk_len = $urandom_range(1, 24);
				for (int k = 0; k < blk_len; k++) begin
					// mostly clean blocks, with a stray early close now and then
					push_pair(pick_sample(), pick_sample(),
						(k == blk_len - 1) || ($urandom_range(31) == 0));
					n++;
				end
			end
		end

		in_valid <= 1'b0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d sample pairs in %0d closed blocks, %0d results checked",
			pairs_sent, blocks_closed, results_seen);
		$display("%0d coefficient loads incl. 0 and 65535, under four source/sink idle mixes",
			coef_writes);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/splm_pkg.sv
rtl/core/splm_db.sv
rtl/core/stereo_peak_level_meter.sv
verif/splm_meter_checker.sv
verif/tb_stereo_peak_level_meter.sv
